// ----- rtl/mm_pkg.sv -----
package mm_pkg;

   // Field widths
   localparam int IDX_W  = 3;
   localparam int DIM_W  = 4;
   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   // Sum of up to eight full-scale Q16.16 products, exact
   localparam int ACC_W  = 36;

   // Span of the 3-bit index fields
   localparam int IDX_SPAN = 8;
   localparam int MAX_DIM_DEFAULT = 8;

   // Operation codes
   localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] OP_COMPUTE    = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT   = 2'd2;

   // Tag that travels with each memory read down the MAC pipe
   typedef struct packed {
      logic               valid;
      logic               first;       // first term of a dot product
      logic               last_inner;  // last term of a dot product
      logic               last_elem;   // final element of the result matrix
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
   } tag_type;

   // Last index of a dimension: 0 counts as 1, values above cap count as cap
   function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] dim,
                                                   input int cap);
      logic [IDX_W-1:0] result;
      if (dim == '0) begin
         result = '0;
      end else if (int'(dim) > cap) begin
         result = IDX_W'(cap - 1);
      end else begin
         result = IDX_W'(dim - DIM_W'(1));
      end
      return result;
   endfunction

endpackage

// ----- rtl/mm_ram.sv -----
module mm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mm_seq.sv -----
module mm_seq #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W  = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mm_pkg::DIM_W-1:0] row_count,
   input  logic [mm_pkg::DIM_W-1:0] inner_count,
   input  logic [mm_pkg::DIM_W-1:0] col_count,
   input  logic                     stall,
   output logic                     busy,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        left_addr,
   output logic [ADDR_W-1:0]        right_addr,
   output mm_pkg::tag_type          tag
);

   localparam int DIM_CAP = (MAX_DIM < mm_pkg::IDX_SPAN) ? MAX_DIM : mm_pkg::IDX_SPAN;

   logic                     busy_ff;
   logic [mm_pkg::IDX_W-1:0] row_lim_ff, inner_lim_ff, col_lim_ff;
   logic [mm_pkg::IDX_W-1:0] i_ff, j_ff, k_ff;
   mm_pkg::tag_type          tag_ff, tag_in;
   logic                     issue, j_end, k_end, i_end;

   assign issue = busy_ff && !stall;
   assign j_end = (j_ff == inner_lim_ff);
   assign k_end = (k_ff == col_lim_ff);
   assign i_end = (i_ff == row_lim_ff);

   // Tag for the read issued this cycle
   always_comb begin
      tag_in            = '0;
      tag_in.valid      = issue;
      tag_in.first      = (j_ff == '0);
      tag_in.last_inner = j_end;
      tag_in.last_elem  = i_end && k_end;
      tag_in.row        = i_ff;
      tag_in.col        = k_ff;
   end

   // Loop counters: inner index fastest, then column, then row
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         tag_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         row_lim_ff   <= '0;
         inner_lim_ff <= '0;
         col_lim_ff   <= '0;
      end else begin
         if (!stall) begin
            tag_ff <= tag_in;
         end
         if (start) begin
            busy_ff      <= 1'b1;
            i_ff         <= '0;
            j_ff         <= '0;
            k_ff         <= '0;
            row_lim_ff   <= mm_pkg::last_index(row_count, DIM_CAP);
            inner_lim_ff <= mm_pkg::last_index(inner_count, DIM_CAP);
            col_lim_ff   <= mm_pkg::last_index(col_count, DIM_CAP);
         end else if (issue) begin
            if (!j_end) begin
               j_ff <= j_ff + mm_pkg::IDX_W'(1);
            end else begin
               j_ff <= '0;
               if (!k_end) begin
                  k_ff <= k_ff + mm_pkg::IDX_W'(1);
               end else begin
                  k_ff <= '0;
                  if (!i_end) begin
                     i_ff <= i_ff + mm_pkg::IDX_W'(1);
                  end else begin
                     busy_ff <= 1'b0;
                  end
               end
            end
         end
      end
   end

   assign busy       = busy_ff;
   assign rd_en      = issue;
   assign left_addr  = ADDR_W'(int'(i_ff) * MAX_DIM + int'(j_ff));
   assign right_addr = ADDR_W'(int'(j_ff) * MAX_DIM + int'(k_ff));
   assign tag        = tag_ff;

endmodule

// ----- rtl/mm_mac.sv -----
module mm_mac (
   input  logic                             clock,
   input  logic                             reset,
   input  mm_pkg::tag_type                  tag,
   input  logic signed [mm_pkg::ELEM_W-1:0] left_data,
   input  logic signed [mm_pkg::ELEM_W-1:0] right_data,
   output logic                             stall,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mm_pkg::IDX_W-1:0]         rsp_result_row,
   output logic [mm_pkg::IDX_W-1:0]         rsp_result_col,
   output logic signed [mm_pkg::PROD_W-1:0] rsp_product_value,
   output logic                             rsp_last_element
);

   localparam int EXT_W = mm_pkg::ACC_W - mm_pkg::PROD_W;

   mm_pkg::tag_type                  tag2_ff;
   logic signed [mm_pkg::PROD_W-1:0] prod_ff;
   logic signed [mm_pkg::ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic signed [mm_pkg::PROD_W-1:0] sat_in;
   logic                             rsp_valid_ff;
   logic [mm_pkg::IDX_W-1:0]         row_ff, col_ff;
   logic signed [mm_pkg::PROD_W-1:0] value_ff;
   logic                             last_ff;
   logic                             overflow;

   // Whole pipe holds while a finished item waits
   assign stall = rsp_valid_ff && !rsp_ready;

   // Accumulate, restarting on the first term
   assign prod_ext = {{EXT_W{prod_ff[mm_pkg::PROD_W-1]}}, prod_ff};
   assign acc_in   = tag2_ff.first ? prod_ext : acc_ff + prod_ext;

   // Saturate to Q16.16: upper bits must all match the sign
   assign overflow = (acc_in[mm_pkg::ACC_W-1:mm_pkg::PROD_W-1] != '0) &&
                     (acc_in[mm_pkg::ACC_W-1:mm_pkg::PROD_W-1] != '1);
   always_comb begin
      if (!overflow) begin
         sat_in = acc_in[mm_pkg::PROD_W-1:0];
      end else if (acc_in[mm_pkg::ACC_W-1]) begin
         sat_in = {1'b1, {(mm_pkg::PROD_W-1){1'b0}}};
      end else begin
         sat_in = {1'b0, {(mm_pkg::PROD_W-1){1'b1}}};
      end
   end

   // Multiply stage, accumulate stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         tag2_ff <= tag;
         if (tag2_ff.valid && tag2_ff.last_inner) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         prod_ff <= mm_pkg::PROD_W'(left_data) * mm_pkg::PROD_W'(right_data);
         if (tag2_ff.valid) begin
            acc_ff <= acc_in;
         end
         if (tag2_ff.valid && tag2_ff.last_inner) begin
            row_ff   <= tag2_ff.row;
            col_ff   <= tag2_ff.col;
            value_ff <= sat_in;
            last_ff  <= tag2_ff.last_elem;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_row    = row_ff;
   assign rsp_result_col    = col_ff;
   assign rsp_product_value = value_ff;
   assign rsp_last_element  = last_ff;

endmodule

// ----- rtl/matrix_multiply_core.sv -----
// Load items: one per cycle while idle, written straight into the element RAMs, no result.
// Compute item: rows*inner*cols reads, one multiply-accumulate a cycle unless the result
// output stalls, bounded by the single read port of each element RAM; each result is registered
// once its dot product's last term is accumulated. No new item is taken while reads issue.
// Reset (synchronous, active high) sets all three dimensions to 1 and empties the pipe;
// element RAMs are not cleared and hold garbage until loaded.
module matrix_multiply_core #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic [mm_pkg::IDX_W-1:0]            req_row_index,
   input  logic [mm_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [mm_pkg::ELEM_W-1:0]    req_element_value,
   // Result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mm_pkg::IDX_W-1:0]            rsp_result_row,
   output logic [mm_pkg::IDX_W-1:0]            rsp_result_col,
   output logic signed [mm_pkg::PROD_W-1:0]    rsp_product_value,
   output logic                                rsp_last_element,
   // Configuration writes
   input  logic                                csr_we,
   input  logic [mm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mm_pkg::DIM_W-1:0]            csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [mm_pkg::DIM_W-1:0] row_count_ff, inner_count_ff, col_count_ff;
   logic                     accept, in_range, start, busy, rd_en, stall;
   logic                     left_we, right_we;
   logic [ADDR_W-1:0]        wr_addr, left_addr, right_addr;
   logic [mm_pkg::ELEM_W-1:0] left_data, right_data;
   mm_pkg::tag_type          tag;

   // Dimension registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= mm_pkg::DIM_W'(1);
         inner_count_ff <= mm_pkg::DIM_W'(1);
         col_count_ff   <= mm_pkg::DIM_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            mm_pkg::CSR_ROW_COUNT:   row_count_ff   <= csr_wdata;
            mm_pkg::CSR_INNER_COUNT: inner_count_ff <= csr_wdata;
            mm_pkg::CSR_COL_COUNT:   col_count_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item decode
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign in_range  = (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);
   assign wr_addr   = ADDR_W'(int'(req_row_index) * MAX_DIM + int'(req_col_index));
   assign left_we   = accept && in_range && (req_operation == mm_pkg::OP_LOAD_LEFT);
   assign right_we  = accept && in_range && (req_operation == mm_pkg::OP_LOAD_RIGHT);
   assign start     = accept && (req_operation == mm_pkg::OP_COMPUTE);

   mm_ram #(
      .WIDTH  (mm_pkg::ELEM_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (rd_en),
      .rd_addr (left_addr),
      .rd_data (left_data)
   );

   mm_ram #(
      .WIDTH  (mm_pkg::ELEM_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (right_we),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (rd_en),
      .rd_addr (right_addr),
      .rd_data (right_data)
   );

   mm_seq #(
      .MAX_DIM (MAX_DIM),
      .ADDR_W  (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .row_count   (row_count_ff),
      .inner_count (inner_count_ff),
      .col_count   (col_count_ff),
      .stall       (stall),
      .busy        (busy),
      .rd_en       (rd_en),
      .left_addr   (left_addr),
      .right_addr  (right_addr),
      .tag         (tag)
   );

   mm_mac u_mac (
      .clock             (clock),
      .reset             (reset),
      .tag               (tag),
      .left_data         (left_data),
      .right_data        (right_data),
      .stall             (stall),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_col    (rsp_result_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_element  (rsp_last_element)
   );

endmodule
